// ----- hdl/rpd_pkg.sv -----
// Shared codes, widths and types of the resource policy debouncer.
`default_nettype none
package rpd_pkg;

	// default widths of the id and timestamp fields
	localparam int TIME_BITS_DEF = 48;
	localparam int ID_BITS_DEF   = 32;
	localparam int COOL_W        = 32;

	typedef logic [1:0] act_t;
	typedef logic [2:0] rsn_t;

	// actions
	localparam act_t ACT_NONE    = 2'd0;
	localparam act_t ACT_NOTIFY  = 2'd1;
	localparam act_t ACT_MEMTUNE = 2'd2;
	localparam act_t ACT_BOOST   = 2'd3;

	// reasons
	localparam rsn_t RSN_NOTASK     = 3'd0;
	localparam rsn_t RSN_CRITICAL   = 3'd1;
	localparam rsn_t RSN_BACKGROUND = 3'd2;
	localparam rsn_t RSN_TIGHT      = 3'd3;
	localparam rsn_t RSN_BOOST      = 3'd4;
	localparam rsn_t RSN_OK         = 3'd5;

	// pressure classes
	localparam logic [1:0] PRS_TIGHT    = 2'd2;
	localparam logic [1:0] PRS_CRITICAL = 2'd3;

	// commands
	localparam logic CMD_EVAL  = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;

	// decision and state update controls from the decision logic
	typedef struct packed {
		act_t action;       // action to report
		rsn_t reason;       // reason to report
		logic suppressed;   // stored decision replayed
		logic acting;       // filter acting state after this item
		logic store_dec;    // fresh decision becomes the stored one
		logic filter_upd;   // filter takes acting flag and timestamp
	} ctl_t;

endpackage
`default_nettype wire

// ----- hdl/resource_policy_debouncer_top.sv -----
// Top level of the resource policy debouncer: handshakes, state and result register.
//
// Takes one item per clock. An item is registered on acceptance, then
// decided against the stored history and placed in the result register
// once that register is free or being taken. While a result waits unread,
// the input register still takes one more item and then holds s_tready
// low until the result register is free or being taken in the same cycle.
// A clear item resets the history and yields no result.
// cooldown_ms is written through the cfg channel, which is always ready.
`default_nettype none
module resource_policy_debouncer_top #(
	parameter int TIME_BITS = rpd_pkg::TIME_BITS_DEF,
	parameter int ID_BITS   = rpd_pkg::ID_BITS_DEF,
	localparam int IN_BITS  = ID_BITS + TIME_BITS + 5,
	localparam int IN_W     = ((IN_BITS + 7) / 8) * 8,
	localparam int OUT_BITS = ID_BITS + rpd_pkg::COOL_W + 7,
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// configuration: cooldown_ms
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [rpd_pkg::COOL_W-1:0]  cfg_data,
	// input items
	input  wire logic                        s_tvalid,
	output logic                             s_tready,
	// task_running, task_id, in_foreground, pause_in_background, pressure, now_ms
	input  wire logic [IN_W-1:0]             s_tdata,
	// cmd
	input  wire logic                        s_tuser,
	// result items
	output logic                             m_tvalid,
	input  wire logic                        m_tready,
	// action, reason, out_task_id, lifetime_ms, suppressed, acting
	output logic [OUT_W-1:0]                 m_tdata
);

	localparam int P_ID  = 1;
	localparam int P_FG  = P_ID + ID_BITS;
	localparam int P_PA  = P_FG + 1;
	localparam int P_PR  = P_FG + 2;
	localparam int P_NOW = P_FG + 4;

	localparam int O_RSN  = 2;
	localparam int O_ID   = 5;
	localparam int O_LIFE = O_ID + ID_BITS;
	localparam int O_SUP  = O_LIFE + rpd_pkg::COOL_W;
	localparam int O_ACT  = O_SUP + 1;

	// configuration register
	logic [rpd_pkg::COOL_W-1:0] cooldown_q;

	// input stage
	logic                 valid_s1;
	logic                 cmd_s1;
	logic                 run_s1;
	logic [ID_BITS-1:0]   id_s1;
	logic                 fg_s1;
	logic                 pause_s1;
	logic [1:0]           prs_s1;
	logic [TIME_BITS-1:0] now_s1;

	// history
	logic                 have_last_q;
	rpd_pkg::act_t        last_action_q;
	rpd_pkg::rsn_t        last_reason_q;
	logic [ID_BITS-1:0]   last_id_q;
	logic                 filter_valid_q;
	logic                 filter_acting_q;
	logic [TIME_BITS-1:0] last_switch_q;

	// result register
	logic                       out_valid_q;
	rpd_pkg::act_t              act_q;
	rpd_pkg::rsn_t              rsn_q;
	logic [ID_BITS-1:0]         oid_q;
	logic [rpd_pkg::COOL_W-1:0] life_q;
	logic                       sup_q;
	logic                       actg_q;

	rpd_pkg::ctl_t ctl;
	logic          advance;
	logic          is_clear;
	logic          is_eval;

	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign is_clear = advance && (cmd_s1 == rpd_pkg::CMD_CLEAR);
	assign is_eval  = advance && (cmd_s1 == rpd_pkg::CMD_EVAL);
	assign s_tready = !valid_s1 || advance;
	assign cfg_ready = 1'b1;
	assign m_tvalid = out_valid_q;

	// cooldown register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cooldown_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			cooldown_q <= cfg_data;
		end
	end

	// input stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	// input stage payload
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1   <= s_tuser;
			run_s1   <= s_tdata[0];
			id_s1    <= s_tdata[P_ID +: ID_BITS];
			fg_s1    <= s_tdata[P_FG];
			pause_s1 <= s_tdata[P_PA];
			prs_s1   <= s_tdata[P_PR +: 2];
			now_s1   <= s_tdata[P_NOW +: TIME_BITS];
		end
	end

	rpd_decide #(
		.TIME_BITS(TIME_BITS),
		.ID_BITS  (ID_BITS)
	) u_decide (
		.task_running       (run_s1),
		.task_id            (id_s1),
		.in_foreground      (fg_s1),
		.pause_in_background(pause_s1),
		.pressure           (prs_s1),
		.now_ms             (now_s1),
		.cooldown_ms        (cooldown_q),
		.have_last          (have_last_q),
		.last_action        (last_action_q),
		.last_reason        (last_reason_q),
		.last_task_id       (last_id_q),
		.filter_valid       (filter_valid_q),
		.filter_acting      (filter_acting_q),
		.last_switch_ms     (last_switch_q),
		.ctl                (ctl)
	);

	// history update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_last_q     <= 1'b0;
			last_action_q   <= rpd_pkg::ACT_NONE;
			last_reason_q   <= rpd_pkg::RSN_NOTASK;
			last_id_q       <= '0;
			filter_valid_q  <= 1'b0;
			filter_acting_q <= 1'b0;
			last_switch_q   <= '0;
		end else if (is_clear) begin
			have_last_q     <= 1'b0;
			last_action_q   <= rpd_pkg::ACT_NONE;
			last_reason_q   <= rpd_pkg::RSN_NOTASK;
			last_id_q       <= '0;
			filter_valid_q  <= 1'b0;
			filter_acting_q <= 1'b0;
			last_switch_q   <= '0;
		end else if (is_eval) begin
			have_last_q <= 1'b1;
			if (ctl.store_dec) begin
				last_action_q <= ctl.action;
				last_reason_q <= ctl.reason;
				last_id_q     <= id_s1;
			end
			if (ctl.filter_upd) begin
				filter_valid_q  <= 1'b1;
				filter_acting_q <= ctl.acting;
				last_switch_q   <= now_s1;
			end
		end
	end

	// result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (is_eval) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (is_eval) begin
			act_q  <= ctl.action;
			rsn_q  <= ctl.reason;
			oid_q  <= ctl.suppressed ? last_id_q : id_s1;
			life_q <= (ctl.action != rpd_pkg::ACT_NONE) ? cooldown_q : '0;
			sup_q  <= ctl.suppressed;
			actg_q <= ctl.acting;
		end
	end

	// pack result item
	always_comb begin
		m_tdata                                = '0;
		m_tdata[1:0]                           = act_q;
		m_tdata[O_RSN +: 3]                    = rsn_q;
		m_tdata[O_ID +: ID_BITS]               = oid_q;
		m_tdata[O_LIFE +: rpd_pkg::COOL_W]     = life_q;
		m_tdata[O_SUP]                         = sup_q;
		m_tdata[O_ACT]                         = actg_q;
	end

	// stored decision always matches the filter state
	a_filter_match: assert property (@(posedge clk) disable iff (!arst_n)
		have_last_q |-> (filter_acting_q == (last_action_q != rpd_pkg::ACT_NONE)))
		else $error("filter state disagrees with stored decision");

	// history and filter are set up together
	a_valid_pair: assert property (@(posedge clk) disable iff (!arst_n)
		have_last_q == filter_valid_q)
		else $error("history valid and filter valid differ");

	// a waiting suppressed result repeats the stored decision
	a_replay: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && sup_q) |-> (act_q == last_action_q && rsn_q == last_reason_q
			&& oid_q == last_id_q && actg_q == filter_acting_q))
		else $error("suppressed result does not repeat stored decision");

endmodule
`default_nettype wire

// ----- hdl/rpd_decide.sv -----
// Rule chain and debounce filter decision for one evaluate item.
`default_nettype none
module rpd_decide #(
	parameter int TIME_BITS = rpd_pkg::TIME_BITS_DEF,
	parameter int ID_BITS   = rpd_pkg::ID_BITS_DEF
) (
	input  wire logic                      task_running,
	input  wire logic [ID_BITS-1:0]        task_id,
	input  wire logic                      in_foreground,
	input  wire logic                      pause_in_background,
	input  wire logic [1:0]                pressure,
	input  wire logic [TIME_BITS-1:0]      now_ms,
	input  wire logic [rpd_pkg::COOL_W-1:0] cooldown_ms,
	input  wire logic                      have_last,
	input  wire rpd_pkg::act_t             last_action,
	input  wire rpd_pkg::rsn_t             last_reason,
	input  wire logic [ID_BITS-1:0]        last_task_id,
	input  wire logic                      filter_valid,
	input  wire logic                      filter_acting,
	input  wire logic [TIME_BITS-1:0]      last_switch_ms,
	output rpd_pkg::ctl_t                  ctl
);

	localparam int CMP_W = (TIME_BITS > rpd_pkg::COOL_W) ? TIME_BITS : rpd_pkg::COOL_W;

	rpd_pkg::act_t        act;
	rpd_pkg::rsn_t        rsn;
	logic                 acting_new;
	logic                 same;
	logic                 eff;
	logic                 upd;
	logic [TIME_BITS-1:0] elapsed;
	logic                 cool_done;

	// fixed rule chain, first match wins
	always_comb begin
		if (!task_running || task_id == '0) begin
			act = rpd_pkg::ACT_NONE;    rsn = rpd_pkg::RSN_NOTASK;
		end else if (pressure == rpd_pkg::PRS_CRITICAL) begin
			act = rpd_pkg::ACT_NOTIFY;  rsn = rpd_pkg::RSN_CRITICAL;
		end else if (!in_foreground && pause_in_background) begin
			act = rpd_pkg::ACT_NONE;    rsn = rpd_pkg::RSN_BACKGROUND;
		end else if (pressure == rpd_pkg::PRS_TIGHT) begin
			act = rpd_pkg::ACT_MEMTUNE; rsn = rpd_pkg::RSN_TIGHT;
		end else if (in_foreground) begin
			act = rpd_pkg::ACT_BOOST;   rsn = rpd_pkg::RSN_BOOST;
		end else begin
			act = rpd_pkg::ACT_NONE;    rsn = rpd_pkg::RSN_OK;
		end
	end

	assign acting_new = (act != rpd_pkg::ACT_NONE);
	assign same       = (act == last_action) && (rsn == last_reason) && (task_id == last_task_id);

	// elapsed time wraps at the timestamp width
	assign elapsed   = now_ms - last_switch_ms;
	assign cool_done = (CMP_W'(elapsed) >= CMP_W'(cooldown_ms));

	// debounce filter
	always_comb begin
		upd = 1'b0;
		eff = filter_acting;
		if (!have_last) begin
			upd = 1'b1;
			eff = acting_new;
		end else if (!same) begin
			if (!filter_valid || (acting_new != filter_acting && cool_done)) begin
				upd = 1'b1;
				eff = acting_new;
			end
		end
	end

	// replay the stored decision when the switch is held back
	always_comb begin
		ctl.filter_upd = upd;
		ctl.acting     = eff;
		ctl.store_dec  = !have_last || (!same && eff == acting_new);
		ctl.suppressed = have_last && !same && eff != acting_new;
		ctl.action     = ctl.suppressed ? last_action : act;
		ctl.reason     = ctl.suppressed ? last_reason : rsn;
	end

endmodule
`default_nettype wire
